@@ rtl/psp_pkg.sv @@
package psp_pkg;

   localparam int MV_W    = 13;
   localparam int PCT_W   = 10;
   localparam int MS_W    = 16;
   localparam int PROD_W  = MV_W + PCT_W;
   localparam int DIV_STEPS = PCT_W;
   localparam int CNT_W   = $clog2(DIV_STEPS);

   localparam logic [PCT_W-1:0] FULL_SCALE           = PCT_W'(1000);
   localparam logic [MV_W-1:0]  WINDOW_MIN_MV        = MV_W'(250);
   localparam logic [MV_W-1:0]  WINDOW_MAX_MV        = MV_W'(4750);
   localparam logic [PCT_W-1:0] BRAKE_ON_LEVEL       = PCT_W'(100);
   localparam logic [PCT_W-1:0] FAULT_CLEAR_LEVEL    = PCT_W'(50);
   localparam logic [PCT_W-1:0] CONFLICT_TRIP_LEVEL  = PCT_W'(250);
   localparam logic [PCT_W-1:0] CONFLICT_CLEAR_LEVEL = PCT_W'(50);
   localparam logic [MS_W-1:0]  TIMER_MAX            = MS_W'(16'hFFFF);

   localparam logic [MV_W-1:0]  RST_LOW_MV    = MV_W'(500);
   localparam logic [MV_W-1:0]  RST_HIGH_MV   = MV_W'(4500);
   localparam logic [PCT_W-1:0] RST_LIMIT     = PCT_W'(100);
   localparam logic [MS_W-1:0]  RST_TIME_MS   = MS_W'(100);

   typedef enum logic [2:0] {
      CSR_A_LOW   = 3'd0,
      CSR_A_HIGH  = 3'd1,
      CSR_B_LOW   = 3'd2,
      CSR_B_HIGH  = 3'd3,
      CSR_BRK_LOW = 3'd4,
      CSR_BRK_HIGH = 3'd5,
      CSR_LIMIT   = 3'd6,
      CSR_TIME_MS = 3'd7
   } csr_idx_type;

   typedef enum logic [1:0] {
      L_IDLE,
      L_MUL,
      L_DIV
   } lane_state_type;

   typedef enum logic [1:0] {
      T_IDLE,
      T_SCALE,
      T_MERGE
   } top_state_type;

   typedef struct packed {
      logic [MV_W-1:0] pedal_a_mv;
      logic [MV_W-1:0] pedal_b_mv;
      logic [MS_W-1:0] elapsed_ms;
   } item_type;

   typedef struct packed {
      logic [PCT_W-1:0] pedal_a_pct;
      logic [PCT_W-1:0] pedal_b_pct;
      logic [PCT_W-1:0] brake_pct;
   } scaled_type;

endpackage

@@ rtl/psp_if.sv @@
interface psp_req_if;
   import psp_pkg::*;
   logic            valid;
   logic            ready;
   logic [MV_W-1:0] pedal_a_mv;
   logic [MV_W-1:0] pedal_b_mv;
   logic [MV_W-1:0] brake_sensor_mv;
   logic [MS_W-1:0] elapsed_ms;

   modport source (output valid, pedal_a_mv, pedal_b_mv, brake_sensor_mv, elapsed_ms,
                   input ready);
   modport sink (input valid, pedal_a_mv, pedal_b_mv, brake_sensor_mv, elapsed_ms,
                 output ready);
endinterface

interface psp_rsp_if;
   import psp_pkg::*;
   logic             valid;
   logic             ready;
   logic [PCT_W-1:0] pedal_out;
   logic [PCT_W-1:0] pedal_a_pct;
   logic [PCT_W-1:0] pedal_b_pct;
   logic [PCT_W-1:0] brake_pct;
   logic             brake_on;
   logic             pedal_a_valid;
   logic             pedal_b_valid;
   logic             pedal_fault;
   logic             brake_conflict;

   modport source (output valid, pedal_out, pedal_a_pct, pedal_b_pct, brake_pct, brake_on,
                   pedal_a_valid, pedal_b_valid, pedal_fault, brake_conflict,
                   input ready);
   modport sink (input valid, pedal_out, pedal_a_pct, pedal_b_pct, brake_pct, brake_on,
                 pedal_a_valid, pedal_b_valid, pedal_fault, brake_conflict,
                 output ready);
endinterface

interface psp_csr_if;
   import psp_pkg::*;
   logic            valid;
   logic            ready;
   csr_idx_type     index;
   logic [MS_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/psp_lane.sv @@
module psp_lane (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [psp_pkg::MV_W-1:0] mv,
   input  logic [psp_pkg::MV_W-1:0] low_mv,
   input  logic [psp_pkg::MV_W-1:0] high_mv,
   output logic                    busy,
   output logic [psp_pkg::PCT_W-1:0] pct
);
   import psp_pkg::*;

   lane_state_type      state_ff, state_in;
   logic [MV_W-1:0]     num_ff, den_ff, rem_ff, rem_in;
   logic                zero_ff, full_ff;
   logic [PCT_W-1:0]    shf_ff, shf_in, pct_ff, pct_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   logic                flipped;
   logic [MV_W-1:0]     num_s, den_s;
   logic                below_s;
   logic [PROD_W-1:0]   prod;
   logic [MV_W:0]       trial;
   logic                fits;

   always_comb begin
      flipped = low_mv > high_mv;
      if (!flipped) begin
         below_s = mv <= low_mv;
         num_s   = mv - low_mv;
         den_s   = high_mv - low_mv;
      end else begin
         below_s = mv >= low_mv;
         num_s   = low_mv - mv;
         den_s   = low_mv - high_mv;
      end
   end

   assign prod  = PROD_W'(num_ff) * PROD_W'(FULL_SCALE);
   assign trial = {rem_ff, shf_ff[PCT_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   // Restoring long division: quotient bits shift in as dividend bits shift out.
   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      shf_in   = shf_ff;
      cnt_in   = cnt_ff;
      pct_in   = pct_ff;
      unique case (state_ff)
         L_IDLE: begin
            if (start) state_in = L_MUL;
         end
         L_MUL: begin
            if (zero_ff) begin
               pct_in   = '0;
               state_in = L_IDLE;
            end else if (full_ff) begin
               pct_in   = FULL_SCALE;
               state_in = L_IDLE;
            end else begin
               rem_in   = prod[PROD_W-1:PCT_W];
               shf_in   = prod[PCT_W-1:0];
               cnt_in   = '0;
               state_in = L_DIV;
            end
         end
         L_DIV: begin
            rem_in = fits ? MV_W'(trial - {1'b0, den_ff}) : trial[MV_W-1:0];
            shf_in = {shf_ff[PCT_W-2:0], fits};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               pct_in   = shf_in;
               state_in = L_IDLE;
            end
         end
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == L_IDLE && start) begin
         num_ff  <= num_s;
         den_ff  <= den_s;
         zero_ff <= below_s || (den_s == '0);
         full_ff <= num_s >= den_s;
      end
      rem_ff <= rem_in;
      shf_ff <= shf_in;
      cnt_ff <= cnt_in;
      pct_ff <= pct_in;
   end

   assign busy = state_ff != L_IDLE;
   assign pct  = pct_ff;

endmodule

@@ rtl/psp_merge.sv @@
module psp_merge (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  psp_pkg::item_type         item,
   input  psp_pkg::scaled_type       scaled,
   input  logic [psp_pkg::PCT_W-1:0] disagree_limit,
   input  logic [psp_pkg::MS_W-1:0]  disagree_time_ms,
   output logic                      free,
   psp_rsp_if.source                 rsp_chan
);
   import psp_pkg::*;

   logic [MS_W-1:0]  timer_ff, timer_in;
   logic             fault_ff, fault_in;
   logic             conflict_ff, conflict_in;
   logic             valid_ff;

   logic [PCT_W-1:0] pedal_out_ff, a_pct_ff, b_pct_ff, brk_pct_ff;
   logic             brake_on_ff, a_ok_ff, b_ok_ff;

   logic             a_ok, b_ok, brake_on, agree;
   logic [PCT_W-1:0] gap, pedal;
   logic [MS_W:0]    sum;

   always_comb begin
      a_ok     = item.pedal_a_mv >= WINDOW_MIN_MV && item.pedal_a_mv <= WINDOW_MAX_MV;
      b_ok     = item.pedal_b_mv >= WINDOW_MIN_MV && item.pedal_b_mv <= WINDOW_MAX_MV;
      brake_on = scaled.brake_pct >= BRAKE_ON_LEVEL;
      gap      = (scaled.pedal_a_pct > scaled.pedal_b_pct) ?
                 scaled.pedal_a_pct - scaled.pedal_b_pct :
                 scaled.pedal_b_pct - scaled.pedal_a_pct;
      agree    = gap <= disagree_limit;
      pedal    = (scaled.pedal_a_pct < scaled.pedal_b_pct) ?
                 scaled.pedal_a_pct : scaled.pedal_b_pct;
      sum      = {1'b0, timer_ff} + {1'b0, item.elapsed_ms};

      if (!a_ok || !b_ok) begin
         timer_in = disagree_time_ms;
      end else if (!agree) begin
         timer_in = sum[MS_W] ? TIMER_MAX : sum[MS_W-1:0];
      end else begin
         timer_in = '0;
      end
      fault_in = fault_ff || (timer_in >= disagree_time_ms);

      // Release needs both channels healthy, in agreement and the pedal near rest.
      if (fault_in && a_ok && b_ok && agree && pedal < FAULT_CLEAR_LEVEL) begin
         fault_in = 1'b0;
         timer_in = '0;
      end

      if (!conflict_ff) begin
         conflict_in = brake_on && pedal > CONFLICT_TRIP_LEVEL;
      end else begin
         conflict_in = !(pedal < CONFLICT_CLEAR_LEVEL);
      end
   end

   assign free = !valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff    <= '0;
         fault_ff    <= 1'b0;
         conflict_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         if (load) begin
            timer_ff    <= timer_in;
            fault_ff    <= fault_in;
            conflict_ff <= conflict_in;
            valid_ff    <= 1'b1;
         end else if (rsp_chan.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pedal_out_ff <= pedal;
         a_pct_ff     <= scaled.pedal_a_pct;
         b_pct_ff     <= scaled.pedal_b_pct;
         brk_pct_ff   <= scaled.brake_pct;
         brake_on_ff  <= brake_on;
         a_ok_ff      <= a_ok;
         b_ok_ff      <= b_ok;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.pedal_out      = pedal_out_ff;
   assign rsp_chan.pedal_a_pct    = a_pct_ff;
   assign rsp_chan.pedal_b_pct    = b_pct_ff;
   assign rsp_chan.brake_pct      = brk_pct_ff;
   assign rsp_chan.brake_on       = brake_on_ff;
   assign rsp_chan.pedal_a_valid  = a_ok_ff;
   assign rsp_chan.pedal_b_valid  = b_ok_ff;
   assign rsp_chan.pedal_fault    = fault_ff;
   assign rsp_chan.brake_conflict = conflict_ff;

endmodule

@@ rtl/pedal_sensor_plausibility_top.sv @@
// Accelerator and brake plausibility check. Each request transfer carries two
// accelerator readings, one brake reading and the milliseconds since the last
// sample; each response transfer returns the three readings scaled to tenths of
// a percent, the lower accelerator channel, window flags, and the latched
// implausibility and brake-and-throttle conflict flags. The three readings are
// scaled by three lanes side by side, each a 13 by 10 bit multiply followed by a
// ten-step restoring divider. The response is registered after all lanes have
// finished and the merge has run, and a new request is taken only once the
// previous item has been merged. A reading that saturates or sits at its zero
// end skips the divider and finishes after the multiply step, but still waits
// for the other lanes. A response left waiting does not block the next request,
// only the merge of that next item, which waits until the response is taken.
// Calibration and the disagreement limits are written through the csr channel,
// which is always ready, and must only be changed while no item is in flight.
module pedal_sensor_plausibility_top (
   input  logic    clock,
   input  logic    reset,
   psp_req_if.sink   req_chan,
   psp_rsp_if.source rsp_chan,
   psp_csr_if.sink   csr_chan
);
   import psp_pkg::*;

   logic [MV_W-1:0]  a_low_ff, a_high_ff, b_low_ff, b_high_ff, brk_low_ff, brk_high_ff;
   logic [PCT_W-1:0] limit_ff;
   logic [MS_W-1:0]  time_ms_ff;

   top_state_type    state_ff, state_in;
   item_type         item_ff;
   scaled_type       scaled;
   logic             start, load, merge_free;
   logic             busy_a, busy_b, busy_brk;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_low_ff    <= RST_LOW_MV;
         a_high_ff   <= RST_HIGH_MV;
         b_low_ff    <= RST_LOW_MV;
         b_high_ff   <= RST_HIGH_MV;
         brk_low_ff  <= RST_LOW_MV;
         brk_high_ff <= RST_HIGH_MV;
         limit_ff    <= RST_LIMIT;
         time_ms_ff  <= RST_TIME_MS;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_A_LOW:    a_low_ff    <= csr_chan.data[MV_W-1:0];
            CSR_A_HIGH:   a_high_ff   <= csr_chan.data[MV_W-1:0];
            CSR_B_LOW:    b_low_ff    <= csr_chan.data[MV_W-1:0];
            CSR_B_HIGH:   b_high_ff   <= csr_chan.data[MV_W-1:0];
            CSR_BRK_LOW:  brk_low_ff  <= csr_chan.data[MV_W-1:0];
            CSR_BRK_HIGH: brk_high_ff <= csr_chan.data[MV_W-1:0];
            CSR_LIMIT:    limit_ff    <= csr_chan.data[PCT_W-1:0];
            CSR_TIME_MS:  time_ms_ff  <= csr_chan.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_chan.ready = 1'b0;
      start          = 1'b0;
      load           = 1'b0;
      unique case (state_ff)
         T_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               start    = 1'b1;
               state_in = T_SCALE;
            end
         end
         T_SCALE: begin
            if (!busy_a && !busy_b && !busy_brk) state_in = T_MERGE;
         end
         T_MERGE: begin
            if (merge_free) begin
               load     = 1'b1;
               state_in = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         item_ff.pedal_a_mv <= req_chan.pedal_a_mv;
         item_ff.pedal_b_mv <= req_chan.pedal_b_mv;
         item_ff.elapsed_ms <= req_chan.elapsed_ms;
      end
   end

   psp_lane u_lane_a (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .mv      (req_chan.pedal_a_mv),
      .low_mv  (a_low_ff),
      .high_mv (a_high_ff),
      .busy    (busy_a),
      .pct     (scaled.pedal_a_pct)
   );

   psp_lane u_lane_b (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .mv      (req_chan.pedal_b_mv),
      .low_mv  (b_low_ff),
      .high_mv (b_high_ff),
      .busy    (busy_b),
      .pct     (scaled.pedal_b_pct)
   );

   psp_lane u_lane_brk (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .mv      (req_chan.brake_sensor_mv),
      .low_mv  (brk_low_ff),
      .high_mv (brk_high_ff),
      .busy    (busy_brk),
      .pct     (scaled.brake_pct)
   );

   psp_merge u_merge (
      .clock            (clock),
      .reset            (reset),
      .load             (load),
      .item             (item_ff),
      .scaled           (scaled),
      .disagree_limit   (limit_ff),
      .disagree_time_ms (time_ms_ff),
      .free             (merge_free),
      .rsp_chan         (rsp_chan)
   );

endmodule

@@ dv/pedal_plausibility_checker.sv @@
module pedal_plausibility_checker
   import psp_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   psp_req_if    req_chan,
   psp_rsp_if    rsp_chan,
   psp_csr_if    csr_chan,
   output int    verdicts_owed,
   output int    mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [PCT_W-1:0] pedal_out;
      logic [PCT_W-1:0] pedal_a_pct;
      logic [PCT_W-1:0] pedal_b_pct;
      logic [PCT_W-1:0] brake_pct;
      logic             brake_on;
      logic             pedal_a_valid;
      logic             pedal_b_valid;
      logic             pedal_fault;
      logic             brake_conflict;
   } pedal_verdict_type;

   pedal_verdict_type pedal_verdicts[$];

   // Calibration shadow and plausibility state.
   logic [MV_W-1:0]  a_lo, a_hi, b_lo, b_hi, brk_lo, brk_hi;
   logic [PCT_W-1:0] agree_window;
   logic [MS_W-1:0]  hold_ms;
   logic [MS_W-1:0]  disagree_ms;
   logic             fault_held;
   logic             conflict_held;

   // A flipped window counts down from its zero-travel end; an empty window gives zero.
   function automatic logic [PCT_W-1:0] tenths(int unsigned mv, int unsigned lo,
                                                int unsigned hi);
      int unsigned num;
      int unsigned den;
      if (lo <= hi) begin
         if (mv <= lo) return '0;
         num = mv - lo;
         den = hi - lo;
      end else begin
         if (mv >= lo) return '0;
         num = lo - mv;
         den = lo - hi;
      end
      if (den == 0) return '0;
      if (num >= den) return FULL_SCALE;
      return PCT_W'((num * FULL_SCALE) / den);
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : track
      pedal_verdict_type want;
      pedal_verdict_type got;
      int unsigned       spread;
      int unsigned       sum;
      logic              agree;

      if (reset) begin
         a_lo          = RST_LOW_MV;
         a_hi          = RST_HIGH_MV;
         b_lo          = RST_LOW_MV;
         b_hi          = RST_HIGH_MV;
         brk_lo        = RST_LOW_MV;
         brk_hi        = RST_HIGH_MV;
         agree_window  = RST_LIMIT;
         hold_ms       = RST_TIME_MS;
         disagree_ms   = '0;
         fault_held    = 1'b0;
         conflict_held = 1'b0;
         mismatch_count = 0;
         pedal_verdicts.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.pedal_out      = rsp_chan.pedal_out;
            got.pedal_a_pct    = rsp_chan.pedal_a_pct;
            got.pedal_b_pct    = rsp_chan.pedal_b_pct;
            got.brake_pct      = rsp_chan.brake_pct;
            got.brake_on       = rsp_chan.brake_on;
            got.pedal_a_valid  = rsp_chan.pedal_a_valid;
            got.pedal_b_valid  = rsp_chan.pedal_b_valid;
            got.pedal_fault    = rsp_chan.pedal_fault;
            got.brake_conflict = rsp_chan.brake_conflict;
            if (pedal_verdicts.size() == 0) begin
               $error("response transfer with no sample outstanding");
               mismatch_count++;
            end else begin
               want = pedal_verdicts.pop_front();
               check_field("pedal_out", want.pedal_out, got.pedal_out);
               check_field("pedal_a_pct", want.pedal_a_pct, got.pedal_a_pct);
               check_field("pedal_b_pct", want.pedal_b_pct, got.pedal_b_pct);
               check_field("brake_pct", want.brake_pct, got.brake_pct);
               check_field("brake_on", want.brake_on, got.brake_on);
               check_field("pedal_a_valid", want.pedal_a_valid, got.pedal_a_valid);
               check_field("pedal_b_valid", want.pedal_b_valid, got.pedal_b_valid);
               check_field("pedal_fault", want.pedal_fault, got.pedal_fault);
               check_field("brake_conflict", want.brake_conflict, got.brake_conflict);
            end
         end

         if (req_chan.valid && req_chan.ready) begin
            want.brake_pct     = tenths(req_chan.brake_sensor_mv, brk_lo, brk_hi);
            want.brake_on      = want.brake_pct >= BRAKE_ON_LEVEL;
            want.pedal_a_valid = req_chan.pedal_a_mv >= WINDOW_MIN_MV &&
                                 req_chan.pedal_a_mv <= WINDOW_MAX_MV;
            want.pedal_b_valid = req_chan.pedal_b_mv >= WINDOW_MIN_MV &&
                                 req_chan.pedal_b_mv <= WINDOW_MAX_MV;
            want.pedal_a_pct   = tenths(req_chan.pedal_a_mv, a_lo, a_hi);
            want.pedal_b_pct   = tenths(req_chan.pedal_b_mv, b_lo, b_hi);
            spread = (want.pedal_a_pct > want.pedal_b_pct) ?
                     want.pedal_a_pct - want.pedal_b_pct :
                     want.pedal_b_pct - want.pedal_a_pct;
            agree = spread <= agree_window;

            // An out-of-window channel trips the timer at once.
            if (!want.pedal_a_valid || !want.pedal_b_valid) begin
               disagree_ms = hold_ms;
            end else if (!agree) begin
               sum = disagree_ms + req_chan.elapsed_ms;
               disagree_ms = (sum > TIMER_MAX) ? TIMER_MAX : MS_W'(sum);
            end else begin
               disagree_ms = '0;
            end
            if (disagree_ms >= hold_ms) fault_held = 1'b1;

            want.pedal_out = (want.pedal_a_pct < want.pedal_b_pct) ?
                             want.pedal_a_pct : want.pedal_b_pct;

            if (fault_held && want.pedal_a_valid && want.pedal_b_valid && agree &&
                want.pedal_out < FAULT_CLEAR_LEVEL) begin
               fault_held  = 1'b0;
               disagree_ms = '0;
            end

            if (!conflict_held) begin
               if (want.brake_on && want.pedal_out > CONFLICT_TRIP_LEVEL)
                  conflict_held = 1'b1;
            end else if (want.pedal_out < CONFLICT_CLEAR_LEVEL) begin
               conflict_held = 1'b0;
            end

            want.pedal_fault    = fault_held;
            want.brake_conflict = conflict_held;
            pedal_verdicts.push_back(want);
         end

         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               CSR_A_LOW:    a_lo = csr_chan.data[MV_W-1:0];
               CSR_A_HIGH:   a_hi = csr_chan.data[MV_W-1:0];
               CSR_B_LOW:    b_lo = csr_chan.data[MV_W-1:0];
               CSR_B_HIGH:   b_hi = csr_chan.data[MV_W-1:0];
               CSR_BRK_LOW:  brk_lo = csr_chan.data[MV_W-1:0];
               CSR_BRK_HIGH: brk_hi = csr_chan.data[MV_W-1:0];
               CSR_LIMIT:    agree_window = csr_chan.data[PCT_W-1:0];
               CSR_TIME_MS:  hold_ms = csr_chan.data;
            endcase
         end
      end
      verdicts_owed <= pedal_verdicts.size();
   end

endmodule

@@ dv/pedal_sensor_plausibility_top_tb.sv @@
module pedal_sensor_plausibility_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import psp_pkg::*;

   localparam int ITEMS_PER_PHASE = 95;
   localparam int PHASES          = 10;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int MV_TOP          = 5000;

   logic clock;
   logic reset;
   logic calm;
   int   cycles = 0;
   int   verdicts_owed;
   int   mismatch_count;

   logic [MS_W-1:0] cal [8];

   psp_req_if req_chan ();
   psp_rsp_if rsp_chan ();
   psp_csr_if csr_chan ();

   pedal_sensor_plausibility_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   pedal_plausibility_checker plaus_chk (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_chan       (csr_chan),
      .verdicts_owed  (verdicts_owed),
      .mismatch_count (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // The response side stalls at random except during the calm stretch.
   always @(posedge clock) begin
      rsp_chan.ready <= calm ? 1'b1 : ($urandom_range(99) >= 33);
   end

   // Millivolts for a given pedal travel in tenths of a percent, with some jitter.
   function automatic int on_travel(logic [MS_W-1:0] lo, logic [MS_W-1:0] hi,
                                    int travel, int jitter);
      int v;
      v = int'(lo) + (int'(hi) - int'(lo)) * travel / 1000
          + int'($urandom_range(2 * jitter)) - jitter;
      if (v < 0) v = 0;
      if (v > MV_TOP) v = MV_TOP;
      return v;
   endfunction

   task automatic send_sample(input logic [MV_W-1:0] a_mv, input logic [MV_W-1:0] b_mv,
                              input logic [MV_W-1:0] brk_mv, input logic [MS_W-1:0] dt);
      while (!calm && $urandom_range(99) < 33) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.pedal_a_mv      <= a_mv;
      req_chan.pedal_b_mv      <= b_mv;
      req_chan.brake_sensor_mv <= brk_mv;
      req_chan.elapsed_ms      <= dt;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (verdicts_owed != 0);
   endtask

   task automatic program_calibration();
      for (int i = 0; i < 8; i++) begin
         csr_chan.valid <= 1'b1;
         csr_chan.index <= csr_idx_type'(i[2:0]);
         csr_chan.data  <= cal[i[2:0]];
         do @(posedge clock); while (!csr_chan.ready);
      end
      csr_chan.valid <= 1'b0;
   endtask

   initial begin
      int kind;
      int travel;
      int a_mv;
      int b_mv;
      int brk_mv;
      int dt;

      calm                     <= 1'b0;
      reset                    <= 1'b1;
      req_chan.valid           <= 1'b0;
      req_chan.pedal_a_mv      <= '0;
      req_chan.pedal_b_mv      <= '0;
      req_chan.brake_sensor_mv <= '0;
      req_chan.elapsed_ms      <= '0;
      csr_chan.valid           <= 1'b0;
      csr_chan.index           <= CSR_A_LOW;
      csr_chan.data            <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed samples against the reset calibration.
      send_sample(0, 0, 0, 0);
      send_sample(5000, 5000, 5000, 16'hFFFF);
      send_sample(250, 250, 500, 7);
      send_sample(249, 300, 0, 1);
      send_sample(4751, 4750, 0, 1);
      send_sample(4750, 4750, 4500, 3);
      send_sample(500, 500, 500, 0);
      send_sample(2500, 1500, 500, 60);
      send_sample(2500, 1500, 500, 39);
      send_sample(2500, 1500, 500, 1);
      send_sample(2500, 1500, 500, 16'hFFFF);
      send_sample(2500, 1500, 500, 16'hFFFF);
      send_sample(520, 500, 500, 0);
      send_sample(700, 700, 899, 0);
      send_sample(1510, 1510, 900, 0);
      send_sample(700, 700, 500, 0);
      send_sample(699, 699, 500, 0);
      send_sample(1500, 1900, 500, 10);
      send_sample(1500, 1904, 500, 10);
      send_sample(4096, 4095, 4096, 16'h8000);
      send_sample(1000, 1000, 4500, 16'h7FFF);
      req_chan.valid <= 1'b0;
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               cal[CSR_A_LOW] = 500;    cal[CSR_A_HIGH] = 4500;
               cal[CSR_B_LOW] = 4500;   cal[CSR_B_HIGH] = 500;
               cal[CSR_BRK_LOW] = 500;  cal[CSR_BRK_HIGH] = 4500;
               cal[CSR_LIMIT] = 100;    cal[CSR_TIME_MS] = 100;
            end
            // Windows at the extremes, A and brake flipped, zero limit and zero fault time.
            1: begin
               cal[CSR_A_LOW] = 4800;   cal[CSR_A_HIGH] = 200;
               cal[CSR_B_LOW] = 0;      cal[CSR_B_HIGH] = 5000;
               cal[CSR_BRK_LOW] = 5000; cal[CSR_BRK_HIGH] = 0;
               cal[CSR_LIMIT] = 0;      cal[CSR_TIME_MS] = 0;
            end
            // Empty windows, widest limit and longest fault time.
            2: begin
               cal[CSR_A_LOW] = 2000;   cal[CSR_A_HIGH] = 2000;
               cal[CSR_B_LOW] = 5000;   cal[CSR_B_HIGH] = 5000;
               cal[CSR_BRK_LOW] = 0;    cal[CSR_BRK_HIGH] = 0;
               cal[CSR_LIMIT] = 1000;   cal[CSR_TIME_MS] = 16'hFFFF;
            end
            3: begin
               cal[CSR_A_LOW] = 0;      cal[CSR_A_HIGH] = 5000;
               cal[CSR_B_LOW] = 250;    cal[CSR_B_HIGH] = 4750;
               cal[CSR_BRK_LOW] = 4500; cal[CSR_BRK_HIGH] = 500;
               cal[CSR_LIMIT] = 1;      cal[CSR_TIME_MS] = 1;
            end
            default: begin
               cal[CSR_A_LOW]    = MS_W'($urandom_range(MV_TOP));
               cal[CSR_A_HIGH]   = MS_W'($urandom_range(MV_TOP));
               cal[CSR_BRK_LOW]  = MS_W'($urandom_range(MV_TOP));
               cal[CSR_BRK_HIGH] = MS_W'($urandom_range(MV_TOP));
               if ($urandom_range(99) < 40) begin
                  cal[CSR_B_LOW]  = cal[CSR_A_LOW];
                  cal[CSR_B_HIGH] = cal[CSR_A_HIGH];
               end else begin
                  cal[CSR_B_LOW]  = MS_W'($urandom_range(MV_TOP));
                  cal[CSR_B_HIGH] = MS_W'($urandom_range(MV_TOP));
               end
               cal[CSR_LIMIT]   = MS_W'($urandom_range(1000));
               cal[CSR_TIME_MS] = $urandom_range(1) ? MS_W'($urandom_range(300))
                                                    : MS_W'($urandom_range(16'hFFFF));
            end
         endcase
         program_calibration();
         calm <= (phase == 5);

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            kind   = $urandom_range(99);
            travel = $urandom_range(1000);
            brk_mv = on_travel(cal[CSR_BRK_LOW], cal[CSR_BRK_HIGH], $urandom_range(1000), 10);
            if (kind < 55) begin
               a_mv = on_travel(cal[CSR_A_LOW], cal[CSR_A_HIGH], travel, 15);
               b_mv = on_travel(cal[CSR_B_LOW], cal[CSR_B_HIGH], travel, 15);
               dt   = $urandom_range(120);
            end else if (kind < 70) begin
               // Near zero travel on both channels, where a latched fault may release.
               travel = $urandom_range(60);
               a_mv = on_travel(cal[CSR_A_LOW], cal[CSR_A_HIGH], travel, 10);
               b_mv = on_travel(cal[CSR_B_LOW], cal[CSR_B_HIGH], travel, 10);
               dt   = $urandom_range(50);
            end else if (kind < 85) begin
               a_mv = on_travel(cal[CSR_A_LOW], cal[CSR_A_HIGH], travel, 0);
               b_mv = $urandom_range(int'(WINDOW_MAX_MV), int'(WINDOW_MIN_MV));
               dt   = $urandom_range(400);
            end else begin
               a_mv   = $urandom_range(MV_TOP);
               b_mv   = $urandom_range(MV_TOP);
               brk_mv = $urandom_range(MV_TOP);
               dt     = $urandom_range(16'hFFFF);
            end
            send_sample(MV_W'(a_mv), MV_W'(b_mv), MV_W'(brk_mv), MS_W'(dt));
         end
         req_chan.valid <= 1'b0;
         calm <= 1'b0;
         wait_drained();
      end

      repeat (30) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/psp_pkg.sv
rtl/psp_if.sv
rtl/psp_lane.sv
rtl/psp_merge.sv
rtl/pedal_sensor_plausibility_top.sv
dv/pedal_plausibility_checker.sv
dv/pedal_sensor_plausibility_top_tb.sv
